// File: rtl/core/lbps_pkg.sv
// ----------------------------------------------------------------------------
// lbps_pkg: shared types and codes for the line buffer pattern search
// Holds the request codes, the internal command word, the configuration
// register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package lbps_pkg;

	// Request codes on the input channel.
	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_EOL    = 2'd1;
	localparam logic [1:0] REQ_EOB    = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_W0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_W1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_W2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_W3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CUR_LINE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CUR_BYTE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd7;

	localparam int CFG_DATA_W = 64;
	localparam int PL_W       = 6;
	localparam int PAT_BYTES  = 32;

	// Bits of the search mode register.
	localparam int MODE_BACK = 0;
	localparam int MODE_WRAP = 1;
	localparam int MODE_NEXT = 2;

	// Queue between the front and the back.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_EOL  = 2'd1,
		CMD_EOB  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [PL_W-1:0]        pat_len;
		logic [3:0][63:0]       pat_words;
		logic [15:0]            start_line;
		logic [12:0]            start_col;
		logic [2:0]             mode;
	} cfg_t;

endpackage

// File: rtl/core/line_buffer_pattern_search.sv
// ----------------------------------------------------------------------------
// line_buffer_pattern_search: streaming text search for a pattern in a line
// Top level: configuration registers, request intake and search engine.
// ----------------------------------------------------------------------------
// Text enters on the request channel (req_valid, req_stall, req_type,
// text_byte) one word per cycle unless stalled: text bytes, end-of-line marks
// and a final end-of-buffer mark. Each end of buffer produces one result word
// on the result channel (res_valid, res_stall, found, match_line, match_byte,
// overflow) and clears the stream state for the next buffer.
// The user must write the pattern, cursor and mode through cfg_we, cfg_index
// and cfg_data only while no buffer is in flight; the block does not enforce it.
// Throughput is one request word per cycle, set by the single window compare
// that checks a full pattern against the last bytes of the line each cycle,
// unless a stall holds it. A result is registered once its end-of-buffer word
// has passed the queue and the second-step flag. When the receiver stalls, the
// result is held in its output register and the engine keeps going until the
// next end of buffer meets it; then a four-entry queue behind the intake fills
// and req_stall rises. Reset clears config, queue, stream counters and flags.
// ----------------------------------------------------------------------------
module line_buffer_pattern_search #(
	parameter int PATTERN_MAX  = 32,
	parameter int LINE_LEN_MAX = 4096,
	parameter int LINES_MAX    = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lbps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbps_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [1:0]                         req_type,
	input  logic [7:0]                         text_byte,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic                               found,
	output logic [15:0]                        match_line,
	output logic [11:0]                        match_byte,
	output logic                               overflow
);
	import lbps_pkg::*;

	cfg_t cfg_q;
	logic head_valid;
	cmd_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAT_LEN:  cfg_q.pat_len      <= cfg_data[PL_W-1:0];
				CFG_PAT_W0:   cfg_q.pat_words[0] <= cfg_data;
				CFG_PAT_W1:   cfg_q.pat_words[1] <= cfg_data;
				CFG_PAT_W2:   cfg_q.pat_words[2] <= cfg_data;
				CFG_PAT_W3:   cfg_q.pat_words[3] <= cfg_data;
				CFG_CUR_LINE: cfg_q.start_line   <= cfg_data[15:0];
				CFG_CUR_BYTE: cfg_q.start_col    <= cfg_data[12:0];
				CFG_MODE:     cfg_q.mode         <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	lbps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.text_byte  (text_byte),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	lbps_back #(
		.PATTERN_MAX  (PATTERN_MAX),
		.LINE_LEN_MAX (LINE_LEN_MAX),
		.LINES_MAX    (LINES_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.found      (found),
		.match_line (match_line),
		.match_byte (match_byte),
		.overflow   (overflow)
	);

endmodule

// File: rtl/core/lbps_front.sv
// ----------------------------------------------------------------------------
// lbps_front: request intake and command queue
// Accepts request words, turns them into commands, drops unused codes and
// buffers the commands in a short queue ahead of the search engine.
// ----------------------------------------------------------------------------
module lbps_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic [7:0]         text_byte,
	output logic               head_valid,
	output lbps_pkg::cmd_t     head,
	input  logic               pop
);
	import lbps_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	cmd_t            cmd;
	logic            keep;
	logic            push;

	always_comb begin
		cmd.data = text_byte;
		keep     = 1'b1;
		case (req_type)
			REQ_BYTE: cmd.kind = CMD_BYTE;
			REQ_EOL:  cmd.kind = CMD_EOL;
			REQ_EOB:  cmd.kind = CMD_EOB;
			default: begin
				// An unused code is taken off the channel and has no effect.
				cmd.kind = CMD_BYTE;
				keep     = 1'b0;
			end
		endcase
	end

	assign req_stall  = (count_q == Q_CW'(Q_DEPTH));
	assign push       = req_valid && !req_stall && keep;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CW'(1);
			end
		end
	end

endmodule

// File: rtl/core/lbps_back.sv
// ----------------------------------------------------------------------------
// lbps_back: search engine
// First step shifts the byte window and tracks line position and count; the
// second step compares the window with the pattern, keeps the primary and
// fallback candidates and builds the result word at end of buffer.
// ----------------------------------------------------------------------------
module lbps_back #(
	parameter int PATTERN_MAX  = 32,
	parameter int LINE_LEN_MAX = 4096,
	parameter int LINES_MAX    = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbps_pkg::cfg_t     cfg,
	input  logic               head_valid,
	input  lbps_pkg::cmd_t     head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               found,
	output logic [15:0]        match_line,
	output logic [11:0]        match_byte,
	output logic               overflow
);
	import lbps_pkg::*;

	localparam int POS_W  = $clog2(LINE_LEN_MAX + 1);
	localparam int LN_W   = $clog2(LINES_MAX);
	localparam int CMPL_W = (LN_W > 16) ? LN_W : 16;
	localparam int CMPP_W = (POS_W > 14) ? POS_W : 14;

	// Pattern aligned to the window, refreshed every cycle from the registers.
	logic [7:0]       pat_bytes [PAT_BYTES];
	logic [PL_W-1:0]  pl_clamp;
	logic [PL_W-1:0]  pl_q;
	logic [7:0]       al_d [PATTERN_MAX];
	logic             care_d [PATTERN_MAX];
	logic [7:0]       al_q [PATTERN_MAX];
	logic             care_q [PATTERN_MAX];
	logic [PL_W-1:0]  idx;

	logic [7:0]       window_q [PATTERN_MAX];
	logic [POS_W-1:0] pos_q;
	logic [LN_W-1:0]  line_q;
	logic             drop_q;
	logic             ovf_q;

	logic             s2_chk_s2;
	logic             s2_eob_s2;
	logic [POS_W-1:0] p1_s2;
	logic [LN_W-1:0]  line_s2;
	logic             ovf_s2;
	logic             cur_ok_s2;

	logic             prim_hit_q;
	logic [15:0]      prim_line_q;
	logic [11:0]      prim_off_q;
	logic             fb_hit_q;
	logic [15:0]      fb_line_q;
	logic [11:0]      fb_off_q;

	logic             res_valid_q;
	logic             found_q;
	logic [15:0]      match_line_q;
	logic [11:0]      match_byte_q;
	logic             overflow_q;

	logic             adv;
	logic             is_byte;
	logic             is_eob;
	logic             byte_ok;
	logic             len_ok;
	logic [CMPP_W-1:0] pos1_x;
	logic             win_eq;
	logic             hit;
	logic [CMPL_W-1:0] ln_x;
	logic [CMPL_W-1:0] cl_x;
	logic [CMPP_W-1:0] s_x;
	logic [CMPP_W-1:0] off_x;
	logic             fwd_ok;
	logic             bwd_ok;
	logic             f_prim;
	logic             f_fb;

	always_comb begin
		for (int j = 0; j < PAT_BYTES; j++) begin
			pat_bytes[j] = cfg.pat_words[j/8][8*(j%8) +: 8];
		end
	end

	assign pl_clamp = (cfg.pat_len > PL_W'(PATTERN_MAX)) ? PL_W'(PATTERN_MAX) : cfg.pat_len;

	// Window slot k holds the byte k places back, so it meets pattern byte
	// pl-1-k; slots at or beyond the length are ignored.
	always_comb begin
		idx = '0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			idx       = pl_clamp - PL_W'(1) - PL_W'(k);
			al_d[k]   = pat_bytes[idx[4:0]];
			care_d[k] = (PL_W'(k) < pl_clamp);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			al_q[k]   <= al_d[k];
			care_q[k] <= care_d[k];
		end
	end

	// The back holds only when a result waits for a busy receiver.
	assign adv     = !(s2_eob_s2 && res_valid_q && res_stall);
	assign pop     = head_valid && adv;
	assign is_byte = (head.kind == CMD_BYTE);
	assign is_eob  = (head.kind == CMD_EOB);
	assign byte_ok = !drop_q && (pos_q < POS_W'(LINE_LEN_MAX));
	assign pos1_x  = CMPP_W'(pos_q) + CMPP_W'(1);
	assign len_ok  = (pl_q != '0) && (pos1_x >= CMPP_W'(pl_q));

	always_ff @(posedge clk) begin
		if (pop && is_byte && byte_ok) begin
			for (int k = PATTERN_MAX - 1; k > 0; k--) begin
				window_q[k] <= window_q[k-1];
			end
			window_q[0] <= head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q      <= '0;
			pos_q     <= '0;
			line_q    <= '0;
			drop_q    <= 1'b0;
			ovf_q     <= 1'b0;
			s2_chk_s2 <= 1'b0;
			s2_eob_s2 <= 1'b0;
		end else begin
			pl_q <= pl_clamp;
			if (adv) begin
				s2_chk_s2 <= pop && is_byte && byte_ok && len_ok;
				s2_eob_s2 <= pop && is_eob;
			end
			if (pop) begin
				case (head.kind)
					CMD_BYTE: begin
						if (!drop_q) begin
							if (pos_q >= POS_W'(LINE_LEN_MAX)) begin
								ovf_q <= 1'b1;
							end else begin
								pos_q <= pos_q + POS_W'(1);
							end
						end
					end
					CMD_EOL: begin
						if (!drop_q) begin
							if (line_q >= LN_W'(LINES_MAX - 1)) begin
								// Line count is full: the rest of the buffer is ignored.
								ovf_q  <= 1'b1;
								drop_q <= 1'b1;
							end else begin
								line_q <= line_q + LN_W'(1);
								pos_q  <= '0;
							end
						end
					end
					CMD_EOB: begin
						pos_q  <= '0;
						line_q <= '0;
						drop_q <= 1'b0;
						ovf_q  <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s2     <= POS_W'(pos1_x);
			line_s2   <= line_q;
			ovf_s2    <= ovf_q;
			cur_ok_s2 <= (CMPL_W'(cfg.start_line) <= CMPL_W'(line_q));
		end
	end

	always_comb begin
		win_eq = 1'b1;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (care_q[k] && (window_q[k] != al_q[k])) begin
				win_eq = 1'b0;
			end
		end
	end

	assign hit    = s2_chk_s2 && win_eq;
	assign ln_x   = CMPL_W'(line_s2);
	assign cl_x   = CMPL_W'(cfg.start_line);
	assign s_x    = CMPP_W'(p1_s2) - CMPP_W'(pl_q);
	assign off_x  = CMPP_W'(cfg.start_col) + (cfg.mode[MODE_NEXT] ? CMPP_W'(pl_q) : '0);
	assign fwd_ok = ((ln_x == cl_x) && (s_x >= off_x)) || (ln_x > cl_x);
	// A backward match must end at or before the cursor byte.
	assign bwd_ok = ((ln_x == cl_x) && (CMPP_W'(p1_s2) <= CMPP_W'(cfg.start_col)))
		|| (ln_x < cl_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_hit_q  <= 1'b0;
			fb_hit_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s2_eob_s2 && adv) begin
				prim_hit_q <= 1'b0;
				fb_hit_q   <= 1'b0;
			end else if (hit) begin
				if (cfg.mode[MODE_BACK] ? bwd_ok : fwd_ok) begin
					prim_hit_q <= 1'b1;
				end
				fb_hit_q <= 1'b1;
			end
			if (s2_eob_s2 && adv) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			if (cfg.mode[MODE_BACK]) begin
				if (bwd_ok) begin
					prim_line_q <= ln_x[15:0];
					prim_off_q  <= s_x[11:0];
				end
				fb_line_q <= ln_x[15:0];
				fb_off_q  <= s_x[11:0];
			end else begin
				if (!prim_hit_q && fwd_ok) begin
					prim_line_q <= ln_x[15:0];
					prim_off_q  <= s_x[11:0];
				end
				if (!fb_hit_q) begin
					fb_line_q <= ln_x[15:0];
					fb_off_q  <= s_x[11:0];
				end
			end
		end
	end

	assign f_prim = cur_ok_s2 && prim_hit_q;
	assign f_fb   = cur_ok_s2 && !prim_hit_q && cfg.mode[MODE_WRAP] && fb_hit_q;

	always_ff @(posedge clk) begin
		if (s2_eob_s2 && adv) begin
			found_q    <= f_prim || f_fb;
			overflow_q <= ovf_s2;
			if (f_prim) begin
				match_line_q <= prim_line_q;
				match_byte_q <= prim_off_q;
			end else if (f_fb) begin
				match_line_q <= fb_line_q;
				match_byte_q <= fb_off_q;
			end else begin
				match_line_q <= '0;
				match_byte_q <= '0;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign found      = found_q;
	assign match_line = match_line_q;
	assign match_byte = match_byte_q;
	assign overflow   = overflow_q;

endmodule

// File: tb/line_buffer_pattern_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_buffer_pattern_search_test: self-checking bench for the pattern search
// Streams text buffers through the request channel and keeps a scoreboard
// with its own model of the search. Every end-of-buffer word queues one
// expected match, which is compared field by field with the result words.
// A directed part covers the mode corners and the length clamp. Random
// buffers with seeded pattern copies then run under several idle and stall
// mixes.
// ----------------------------------------------------------------------------
module line_buffer_pattern_search_test;
	import lbps_pkg::*;

	localparam int PATTERN_MAX  = 32;
	localparam int LINE_LEN_MAX = 4096;
	localparam int LINES_MAX    = 65536;

	localparam logic [2:0] M_FWD  = 3'd0;
	localparam logic [2:0] M_BACK = 3'(1 << MODE_BACK);
	localparam logic [2:0] M_WRAP = 3'(1 << MODE_WRAP);
	localparam logic [2:0] M_NEXT = 3'(1 << MODE_NEXT);

	typedef struct packed {
		logic        hit;
		logic [15:0] line_idx;
		logic [11:0] start;
		logic        ovf;
	} match_result_t;

	// Scoreboard: tracks the search state word by word and holds the
	// matches that the block still owes.
	class match_tracker;
		bit [5:0]     pat_len;
		bit [255:0]   pat_bits;
		bit [15:0]    start_line;
		bit [12:0]    start_col;
		bit [2:0]     mode;
		bit [7:0]     window [PATTERN_MAX];
		int unsigned  line_pos;
		int unsigned  line_cnt;
		bit           main_hit;
		int unsigned  main_line;
		int unsigned  main_start;
		bit           wrap_hit;
		int unsigned  wrap_line;
		int unsigned  wrap_start;
		bit           ovf_seen;
		bit           dropping;
		match_result_t pending_matches[$];
		int           errors;

		function new();
			pat_len    = '0;
			pat_bits   = '0;
			start_line = '0;
			start_col  = '0;
			mode       = '0;
			errors     = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			foreach (window[k])
				window[k] = 8'h00;
			line_pos   = 0;
			line_cnt   = 0;
			main_hit   = 1'b0;
			main_line  = 0;
			main_start = 0;
			wrap_hit   = 1'b0;
			wrap_line  = 0;
			wrap_start = 0;
			ovf_seen   = 1'b0;
			dropping   = 1'b0;
		endfunction

		function int pending();
			return pending_matches.size();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PAT_LEN:  pat_len = data[5:0];
				CFG_PAT_W0:   pat_bits[63:0] = data;
				CFG_PAT_W1:   pat_bits[127:64] = data;
				CFG_PAT_W2:   pat_bits[191:128] = data;
				CFG_PAT_W3:   pat_bits[255:192] = data;
				CFG_CUR_LINE: start_line = data[15:0];
				CFG_CUR_BYTE: start_col = data[12:0];
				CFG_MODE:     mode = data[2:0];
				default: ;
			endcase
		endfunction

		function void record_match(int unsigned ln, int unsigned s, int unsigned used);
			int unsigned lim;
			if (!mode[MODE_BACK]) begin
				lim = start_col;
				if (mode[MODE_NEXT])
					lim += used;
				if (!main_hit && ((ln == start_line && s >= lim) || ln > start_line)) begin
					main_hit   = 1'b1;
					main_line  = ln;
					main_start = s;
				end
				if (!wrap_hit) begin
					wrap_hit   = 1'b1;
					wrap_line  = ln;
					wrap_start = s;
				end
			end else begin
				// Backward keeps the last match that ends at or before the cursor.
				if ((ln == start_line && s + used <= start_col) || ln < start_line) begin
					main_hit   = 1'b1;
					main_line  = ln;
					main_start = s;
				end
				wrap_hit   = 1'b1;
				wrap_line  = ln;
				wrap_start = s;
			end
		endfunction

		function void take_byte(logic [7:0] b);
			int unsigned p;
			int unsigned used;
			int          k;
			bit          same;
			if (dropping)
				return;
			if (line_pos >= LINE_LEN_MAX) begin
				ovf_seen = 1'b1;
				return;
			end
			for (k = PATTERN_MAX - 1; k > 0; k--)
				window[k] = window[k-1];
			window[0] = b;
			p = line_pos;
			line_pos = p + 1;
			used = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
			if (used == 0 || p + 1 < used)
				return;
			same = 1'b1;
			for (k = 0; k < used; k++)
				if (window[k] != pat_bits[8*(used-1-k) +: 8])
					same = 1'b0;
			if (same)
				record_match(line_cnt, p + 1 - used, used);
		endfunction

		function void take_eol();
			if (dropping)
				return;
			if (line_cnt >= LINES_MAX - 1) begin
				ovf_seen = 1'b1;
				dropping = 1'b1;
				return;
			end
			line_cnt++;
			line_pos = 0;
		endfunction

		function void close_buffer();
			match_result_t r;
			r = '0;
			if (start_line <= line_cnt) begin
				if (main_hit) begin
					r.hit      = 1'b1;
					r.line_idx = main_line[15:0];
					r.start    = main_start[11:0];
				end else if (mode[MODE_WRAP] && wrap_hit) begin
					r.hit      = 1'b1;
					r.line_idx = wrap_line[15:0];
					r.start    = wrap_start[11:0];
				end
			end
			r.ovf = ovf_seen;
			pending_matches.push_back(r);
			clear_stream();
		endfunction

		function void note_word(logic [1:0] kind, logic [7:0] b);
			case (kind)
				REQ_BYTE: take_byte(b);
				REQ_EOL:  take_eol();
				REQ_EOB:  close_buffer();
				default: ;
			endcase
		endfunction

		task report_mismatch(string what, longint unsigned got, longint unsigned want);
			errors++;
			$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		endtask

		task check_result(logic hit, logic [15:0] ml, logic [11:0] mb, logic ovf);
			match_result_t want;
			if (pending_matches.size() == 0) begin
				report_mismatch("unexpected result word", {ml, mb}, 0);
				return;
			end
			want = pending_matches.pop_front();
			if (hit !== want.hit)
				report_mismatch("found", hit, want.hit);
			if (ml !== want.line_idx)
				report_mismatch("match_line", ml, want.line_idx);
			if (mb !== want.start)
				report_mismatch("match_byte", mb, want.start);
			if (ovf !== want.ovf)
				report_mismatch("overflow", ovf, want.ovf);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [1:0]            req_type = REQ_BYTE;
	logic [7:0]            text_byte = 8'h00;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic                  found;
	logic [15:0]           match_line;
	logic [11:0]           match_byte;
	logic                  overflow;

	match_tracker tracker;
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	int           words_sent = 0;
	logic [255:0] cur_pat_bits = '0;
	int           cur_pat_len = 0;

	line_buffer_pattern_search #(
		.PATTERN_MAX (PATTERN_MAX),
		.LINE_LEN_MAX(LINE_LEN_MAX),
		.LINES_MAX   (LINES_MAX)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.text_byte (text_byte),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.found     (found),
		.match_line(match_line),
		.match_byte(match_byte),
		.overflow  (overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_result(found, match_line, match_byte, overflow);
	end

	// Sends one word and returns at the edge that accepted it.
	task send_word(logic [1:0] kind, logic [7:0] b);
		cfg_we <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		text_byte <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		tracker.note_word(kind, b);
		if (kind != REQ_UNUSED)
			words_sent++;
	endtask

	// Lets every owed result come out with the request and configuration channels idle.
	task settle();
		req_valid <= 1'b0;
		cfg_we    <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	task load_pattern(logic [255:0] bits, logic [5:0] len);
		write_reg(CFG_PAT_LEN, {58'd0, len});
		write_reg(CFG_PAT_W0, bits[63:0]);
		write_reg(CFG_PAT_W1, bits[127:64]);
		write_reg(CFG_PAT_W2, bits[191:128]);
		write_reg(CFG_PAT_W3, bits[255:192]);
		cur_pat_bits = bits;
		cur_pat_len  = (len > PATTERN_MAX) ? PATTERN_MAX : len;
	endtask

	task set_search(logic [15:0] ln, logic [12:0] pos, logic [2:0] m);
		logic [CFG_DATA_W-1:0] junk;
		// Bits above each register's width should be ignored by the block.
		junk = ($urandom_range(4) == 0) ? {$urandom, $urandom} : '0;
		write_reg(CFG_CUR_LINE, {junk[63:16], ln});
		write_reg(CFG_CUR_BYTE, {junk[63:13], pos});
		write_reg(CFG_MODE, {junk[63:3], m});
	endtask

	// A newline in the text stands for an end-of-line word.
	task send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			if (s[i] == "\n")
				send_word(REQ_EOL, 8'($urandom));
			else
				send_word(REQ_BYTE, s[i]);
		end
		send_word(REQ_EOB, 8'($urandom));
	endtask

	task run_directed();
		// Pattern length zero never matches.
		send_text("");
		send_word(REQ_UNUSED, 8'hA5);
		send_text("ab\nab");
		load_pattern(256'h6261, 6'd2);
		set_search(16'd0, 13'd0, M_FWD);
		send_text("xab\nab");
		set_search(16'd0, 13'd1, M_NEXT);
		send_text("xab\nab");
		set_search(16'd1, 13'd1, M_BACK);
		send_text("xab\nab");
		set_search(16'd0, 13'd0, M_BACK | M_WRAP);
		send_text("xab\nab");
		set_search(16'd1, 13'd5, M_WRAP);
		send_text("xab\nab");
		// Cursor past the last line hides the match even with wrap.
		set_search(16'd5, 13'd0, M_WRAP);
		send_text("xab\nab");

		// Length above the window clamps to the full 32 bytes.
		load_pattern({16{16'h00FF}}, 6'd63);
		set_search(16'd0, 13'd0, M_FWD);
		send_word(REQ_BYTE, 8'h63);
		for (int k = 0; k < PATTERN_MAX; k++)
			send_word(REQ_BYTE, (k % 2 == 0) ? 8'hFF : 8'h00);
		send_word(REQ_EOB, 8'h00);
	endtask

	task random_buffer();
		int           n_lines;
		int           line_len;
		int           i;
		int           pick;
		logic [5:0]   len;
		logic [255:0] bits;
		logic [7:0]   alpha [3];
		logic [15:0]  ln;
		logic [12:0]  pos;
		n_lines = ($urandom_range(19) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
		if ($urandom_range(9) < 7) begin
			if ($urandom_range(9) < 6) begin
				pick = $urandom_range(99);
				if (pick < 8)
					len = 6'd0;
				else if (pick < 65)
					len = 6'($urandom_range(1, 4));
				else if (pick < 90)
					len = 6'($urandom_range(5, 32));
				else
					len = 6'($urandom_range(33, 63));
				for (int w = 0; w < 8; w++)
					bits[32*w +: 32] = $urandom;
				// Mostly a two-letter alphabet so that matches overlap and repeat.
				if ($urandom_range(9) < 8)
					for (int k = 0; k < PATTERN_MAX; k++)
						bits[8*k +: 8] = 8'h61 + 8'($urandom_range(1));
				load_pattern(bits, len);
			end
			pick = $urandom_range(99);
			if (pick < 80)
				ln = 16'($urandom_range(n_lines - 1));
			else if (pick < 90)
				ln = 16'(n_lines + $urandom_range(2));
			else if (pick < 95)
				ln = 16'hFFFF;
			else
				ln = 16'($urandom);
			pick = $urandom_range(99);
			if (pick < 85)
				pos = 13'($urandom_range(35));
			else if (pick < 95)
				pos = 13'd4096;
			else
				pos = 13'($urandom_range(4096));
			set_search(ln, pos, 3'($urandom_range(7)));
		end
		alpha[0] = cur_pat_bits[7:0];
		alpha[1] = cur_pat_bits[15:8];
		alpha[2] = ($urandom_range(1) == 0) ? 8'h63 : 8'($urandom);
		for (int l = 0; l < n_lines; l++) begin
			line_len = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(24);
			i = 0;
			while (i < line_len) begin
				if ($urandom_range(31) == 0) begin
					send_word(REQ_UNUSED, 8'($urandom));
				end else if (cur_pat_len > 0 && $urandom_range(7) == 0) begin
					for (int k = 0; k < cur_pat_len; k++)
						send_word(REQ_BYTE, cur_pat_bits[8*k +: 8]);
					i += cur_pat_len;
				end else begin
					if ($urandom_range(9) < 8)
						send_word(REQ_BYTE, alpha[$urandom_range(2)]);
					else
						send_word(REQ_BYTE, 8'($urandom));
					i++;
				end
			end
			if (l < n_lines - 1)
				send_word(REQ_EOL, 8'($urandom));
		end
		send_word(REQ_EOB, 8'($urandom));
	endtask

	initial begin
		int start;
		tracker = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 54; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 54; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			start = words_sent;
			while (words_sent - start < 400)
				random_buffer();
		end
		req_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/lbps_pkg.sv
rtl/core/lbps_front.sv
rtl/core/lbps_back.sv
rtl/core/line_buffer_pattern_search.sv
tb/line_buffer_pattern_search_test.sv
